/* hw/rtl/multi_axis_nco_step_generator_defines.svh */
// Assertion macros shared by the step generator RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef MULTI_AXIS_NCO_STEP_GENERATOR_DEFINES_SVH
`define MULTI_AXIS_NCO_STEP_GENERATOR_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define MANSG_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define MANSG_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/mansg_pkg.sv */
// Package for the multi-axis step generator: sizes, beat layout and lane structs.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package mansg_pkg;

    localparam int AXES        = 4;
    localparam int ACC_WIDTH   = 16;
    localparam int COUNT_WIDTH = 16;

    // Width of the per-axis fields in a result beat.
    localparam int STATUS_BITS = 4;

    localparam int AXIS_W   = 2;
    localparam int MOVE_W   = 16;
    localparam int IN_BITS  = AXIS_W + MOVE_W + MOVE_W + 1;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 4 * STATUS_BITS + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic {
        FUNC_TICK  = 1'b0,
        FUNC_QUEUE = 1'b1
    } func_t;

    // Per-lane command for the current beat.
    typedef struct packed {
        logic                   tick;
        logic                   wr;
        logic [COUNT_WIDTH-1:0] steps;
        logic [ACC_WIDTH-1:0]   rate;
        logic                   dir;
    } lane_ctrl_t;

    // Per-lane status; all but slot_busy reflect the state after the beat.
    typedef struct packed {
        logic step_low;
        logic dir;
        logic full;
        logic moving;
        logic slot_busy;
    } lane_stat_t;

endpackage

/* hw/rtl/mansg_lane.sv */
// One axis: phase accumulator, step counter and one-deep next-move slot.
// Depends on mansg_pkg.
`timescale 1ns / 1ps

module mansg_lane
    import mansg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  lane_ctrl_t ctrl,
    output lane_stat_t stat
);

    logic [ACC_WIDTH-1:0]   acc_reg, acc_next;
    logic [COUNT_WIDTH-1:0] steps_reg, steps_next;
    logic [ACC_WIDTH-1:0]   rate_reg, rate_next;
    logic                   dir_reg, dir_next;
    logic                   qv_reg, qv_next;
    logic [COUNT_WIDTH-1:0] q_steps_reg;
    logic [ACC_WIDTH-1:0]   q_rate_reg;
    logic                   q_dir_reg;
    logic [ACC_WIDTH:0]     sum;
    logic                   low;

    assign sum = {1'b0, acc_reg} + {1'b0, rate_reg};

    always_comb
    begin
        acc_next   = acc_reg;
        steps_next = steps_reg;
        rate_next  = rate_reg;
        dir_next   = dir_reg;
        qv_next    = qv_reg;
        low        = 1'b0;
        if (ctrl.tick)
        begin
            acc_next = sum[ACC_WIDTH-1:0];
            if (steps_reg != '0)
            begin
                // The carry out of the accumulator is the step trigger.
                if (sum[ACC_WIDTH])
                begin
                    steps_next = steps_reg - COUNT_WIDTH'(1);
                    low        = 1'b1;
                end
            end
            else if (qv_reg)
            begin
                qv_next    = 1'b0;
                steps_next = q_steps_reg;
                rate_next  = q_rate_reg;
                dir_next   = q_dir_reg;
            end
        end
        else if (ctrl.wr && !qv_reg)
        begin
            qv_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            steps_reg <= '0;
            rate_reg  <= '0;
            dir_reg   <= 1'b0;
            qv_reg    <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            steps_reg <= steps_next;
            rate_reg  <= rate_next;
            dir_reg   <= dir_next;
            qv_reg    <= qv_next;
        end
    end

    // The slot contents are only read while the slot is marked full.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr && !qv_reg)
        begin
            q_steps_reg <= ctrl.steps;
            q_rate_reg  <= ctrl.rate;
            q_dir_reg   <= ctrl.dir;
        end
    end

    assign stat.step_low  = low;
    assign stat.dir       = dir_next;
    assign stat.full      = qv_next;
    assign stat.moving    = (steps_next != '0);
    assign stat.slot_busy = qv_reg;

endmodule

/* hw/rtl/mansg_merge.sv */
// Merging stage: gathers lane status into a result beat and holds it in the
// output register. Depends on mansg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "multi_axis_nco_step_generator_defines.svh"

module mansg_merge
    import mansg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  accept,
    input  logic                  is_queue,
    input  logic                  axis_oob,
    input  logic [AXES-1:0]       sel,
    input  lane_stat_t            stat [AXES],
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data
);

    logic [STATUS_BITS-1:0] low_bits, dir_bits, full_bits, mov_bits;
    logic [AXES-1:0]        busy;
    logic                   rejected;
    logic                   valid_reg, valid_next;
    logic [OUT_DATA_W-1:0]  data_reg, data_next;

    for (genvar a = 0; a < AXES; a++)
    begin : g_busy
        assign busy[a] = stat[a].slot_busy;
    end

    for (genvar b = 0; b < STATUS_BITS; b++)
    begin : g_bits
        if (b < AXES)
        begin : g_lane
            assign low_bits[b]  = stat[b].step_low;
            assign dir_bits[b]  = stat[b].dir;
            assign full_bits[b] = stat[b].full;
            assign mov_bits[b]  = stat[b].moving;
        end
        else
        begin : g_none
            assign low_bits[b]  = 1'b0;
            assign dir_bits[b]  = 1'b0;
            assign full_bits[b] = 1'b0;
            assign mov_bits[b]  = 1'b0;
        end
    end

    assign rejected = is_queue && (axis_oob || ((sel & busy) != '0));

    // A new beat enters whenever the output register is empty or drains now.
    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            data_next  = OUT_DATA_W'({rejected, mov_bits, full_bits, dir_bits, low_bits});
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    `MANSG_ASSERT_SAME(a_no_overrun, clk, rst_n, valid_reg && !out_ready, !accept, "beat accepted over a stalled result")
    `MANSG_ASSERT_NEXT(a_result_follows, clk, rst_n, accept, valid_reg, "accepted beat produced no result")
    `MANSG_ASSERT_SAME(a_queue_no_step, clk, rst_n, accept && is_queue, low_bits == '0, "step pulse on a queue beat")
    `MANSG_ASSERT_SAME(a_tick_no_reject, clk, rst_n, accept && !is_queue, !rejected, "tick beat flagged as rejected")

endmodule

/* hw/rtl/multi_axis_nco_step_generator.sv */
// Top level of the multi-axis step generator: beat decode, axis lanes, merge.
// Depends on mansg_pkg, mansg_lane and mansg_merge.
//
//   Channel | Direction | Beat contents
//   s_*     | in        | tuser: func; tdata: axis, move_steps, move_rate, move_direction
//   m_*     | out       | tdata: step_low, direction_lines, slot_full, moving, rejected
//
// Every accepted beat updates the lanes (a tick all, a queue one slot); its result is in
// the output register on the next cycle: one beat per cycle while m_tready is high.
// The output register decouples the sides: s_tready is low only while a result
// is held and m_tready is low.
// Reset clears accumulators, counters, rates, directions and slot flags at once.
`timescale 1ns / 1ps

module multi_axis_nco_step_generator
    import mansg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // axis, move_steps, move_rate, move_direction
    input  logic                  s_tuser,  // func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata   // step_low, direction_lines, slot_full, moving,
                                            // rejected
);

    localparam int STEPS_LSB = AXIS_W;
    localparam int RATE_LSB  = AXIS_W + MOVE_W;
    localparam int DIR_BIT   = AXIS_W + 2 * MOVE_W;

    logic [AXIS_W-1:0] axis;
    logic [MOVE_W-1:0] move_steps, move_rate;
    logic              move_direction;
    logic              is_queue, axis_oob, accept;
    logic [AXES-1:0]   sel;
    lane_ctrl_t        ctrl [AXES];
    lane_stat_t        stat [AXES];

    assign axis           = s_tdata[AXIS_W-1:0];
    assign move_steps     = s_tdata[STEPS_LSB +: MOVE_W];
    assign move_rate      = s_tdata[RATE_LSB +: MOVE_W];
    assign move_direction = s_tdata[DIR_BIT];
    assign is_queue       = (func_t'(s_tuser) == FUNC_QUEUE);
    assign axis_oob       = (32'(axis) >= AXES);

    for (genvar a = 0; a < AXES; a++)
    begin : g_lane
        assign sel[a]        = (32'(axis) == a);
        assign ctrl[a].tick  = accept && !is_queue;
        assign ctrl[a].wr    = accept && is_queue && sel[a];
        assign ctrl[a].steps = COUNT_WIDTH'(move_steps);
        assign ctrl[a].rate  = ACC_WIDTH'(move_rate);
        assign ctrl[a].dir   = move_direction;

        mansg_lane u_lane (
            .clk  (clk),
            .rst_n(rst_n),
            .ctrl (ctrl[a]),
            .stat (stat[a])
        );
    end

    mansg_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .accept   (accept),
        .is_queue (is_queue),
        .axis_oob (axis_oob),
        .sel      (sel),
        .stat     (stat),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (m_tdata)
    );

endmodule
